// File: src/string_escape_decoder_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the string escape decoder
// Shared helpers; each expands to one labeled concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef STRING_ESCAPE_DECODER_CORE_DEFINES_SVH
`define STRING_ESCAPE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, idle during reset
`define SED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define SED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define SED_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sed_pkg.sv
// ---------------------------------------------------------------------------
// sed_pkg
// Shared types, character codes and helpers of the string escape decoder.
// ---------------------------------------------------------------------------
package sed_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] MAX_BYTES_RESET = 16'd1024;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // results one input item causes, in output order: held digit, byte, end
  typedef struct packed {
    logic             hv;
    logic [7:0]       hb;
    logic             cv;
    logic [7:0]       cb;
    logic             ev;
    logic [CNT_W-1:0] cnt;
  } sed_rec_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, c[3:0]};
    else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// File: src/sed_front.sv
// ---------------------------------------------------------------------------
// sed_front
// Accepts raw bytes, runs the escape state machine and writes one record of
// up to three results per item into the queue.
// ---------------------------------------------------------------------------
module sed_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              raw_byte,
  input  logic                    is_last,
  input  logic [sed_pkg::CNT_W-1:0] max_bytes,
  input  logic                    q_full,
  output logic                    q_push,
  output sed_pkg::sed_rec_t       q_rec
);
  import sed_pkg::*;

  localparam logic [2:0] M_START = 3'd0;
  localparam logic [2:0] M_PLAIN = 3'd1;
  localparam logic [2:0] M_ESC   = 3'd2;
  localparam logic [2:0] M_HEX1  = 3'd3;
  localparam logic [2:0] M_HEX2  = 3'd4;
  localparam logic [2:0] M_DONE  = 3'd5;

  logic [2:0]       mode, mode_next;
  logic [7:0]       held_char, held_next;
  logic [CNT_W-1:0] emitted_count, cnt1, cnt2;
  logic             want0, want1, accept;
  logic [7:0]       byte0, byte1;
  logic [4:0]       hc, hh;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hc = hex_val(raw_byte);
  assign hh = hex_val(held_char);

  always_comb begin
    mode_next = mode;
    held_next = held_char;
    want0 = 1'b0;
    want1 = 1'b0;
    byte0 = held_char;
    byte1 = raw_byte;
    // plain-text handling of the current byte, reused by several modes
    case (mode)
      M_START: begin
        if (raw_byte == CH_QUOTE) mode_next = M_PLAIN;
        else if (raw_byte == CH_BSLASH && !is_last) mode_next = M_ESC;
        else begin
          want1 = 1'b1;
          mode_next = M_PLAIN;
        end
      end
      M_ESC: begin
        mode_next = M_PLAIN;
        want1 = 1'b1;
        if (raw_byte == CH_N) byte1 = CH_LF;
        else if (raw_byte == CH_R) byte1 = CH_CR;
        else if (raw_byte == CH_T) byte1 = CH_TAB;
        else if (raw_byte inside {CH_BSLASH, CH_QUOTE}) byte1 = raw_byte;
        else if (raw_byte == CH_X) begin
          want1 = 1'b0;
          if (!is_last) mode_next = M_HEX1;
        end else byte1 = CH_BSLASH;
      end
      M_HEX1: begin
        if (!is_last && hc[4]) begin
          held_next = raw_byte;
          mode_next = M_HEX2;
        end else if (raw_byte == CH_QUOTE) mode_next = M_DONE;
        else if (raw_byte == CH_BSLASH && !is_last) mode_next = M_ESC;
        else begin
          want1 = 1'b1;
          mode_next = M_PLAIN;
        end
      end
      M_HEX2: begin
        held_next = 8'd0;
        if (hc[4]) begin
          want1 = 1'b1;
          byte1 = {hh[3:0], hc[3:0]};
          mode_next = M_PLAIN;
        end else begin
          want0 = 1'b1;
          if (raw_byte == CH_QUOTE) mode_next = M_DONE;
          else if (raw_byte == CH_BSLASH && !is_last) mode_next = M_ESC;
          else begin
            want1 = 1'b1;
            mode_next = M_PLAIN;
          end
        end
      end
      M_DONE: ;
      default: begin
        if (raw_byte == CH_QUOTE) mode_next = M_DONE;
        else if (raw_byte == CH_BSLASH && !is_last) mode_next = M_ESC;
        else begin
          want1 = 1'b1;
          mode_next = M_PLAIN;
        end
      end
    endcase
  end

  // byte limit applied to each emit in order
  always_comb begin
    q_rec.hv  = want0 && (emitted_count < max_bytes);
    q_rec.hb  = byte0;
    cnt1      = emitted_count + CNT_W'(q_rec.hv);
    q_rec.cv  = want1 && (cnt1 < max_bytes);
    q_rec.cb  = byte1;
    cnt2      = cnt1 + CNT_W'(q_rec.cv);
    q_rec.ev  = is_last;
    q_rec.cnt = cnt2;
  end

  assign q_push = accept && (q_rec.hv || q_rec.cv || q_rec.ev);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START;
      held_char <= 8'd0;
      emitted_count <= '0;
    end else if (accept) begin
      if (is_last) begin
        mode <= M_START;
        held_char <= 8'd0;
        emitted_count <= '0;
      end else begin
        mode <= mode_next;
        held_char <= held_next;
        emitted_count <= cnt2;
      end
    end
  end

endmodule

// File: src/sed_queue.sv
// ---------------------------------------------------------------------------
// sed_queue
// Small FIFO of result records between the front and back parts.
// ---------------------------------------------------------------------------
module sed_queue #(
  parameter int DEPTH = sed_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sed_pkg::sed_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sed_pkg::sed_rec_t head_rec
);
  import sed_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  sed_rec_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// File: src/sed_back.sv
// ---------------------------------------------------------------------------
// sed_back
// Walks the head record of the queue and sends its results one per cycle
// through an output register while out_ready lets the register take a new one.
// ---------------------------------------------------------------------------
module sed_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  sed_pkg::sed_rec_t head_rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_byte,
  output logic [sed_pkg::CNT_W-1:0] out_count,
  output logic              out_last
);
  import sed_pkg::*;

  logic [2:0] sent, pending, pick, rest;
  logic       load, fin;

  assign pending = {head_rec.ev, head_rec.cv, head_rec.hv} & ~sent;
  assign pick    = pending & (~pending + 3'd1);   // lowest pending result
  assign rest    = pending & ~pick;
  assign fin     = (rest == 3'd0);
  assign load    = head_valid && (!out_valid || out_ready);
  assign pop     = load && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sent <= fin ? 3'd0 : (sent | pick);
      end else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= pick[2];
      out_last  <= fin;
      out_byte  <= pick[0] ? head_rec.hb : (pick[1] ? head_rec.cb : 8'd0);
      out_count <= pick[2] ? head_rec.cnt : '0;
    end
  end

endmodule

// File: src/string_escape_decoder_core.sv
// ---------------------------------------------------------------------------
// string_escape_decoder_core
// Decodes C-style escapes in a quoted string token, one raw byte per item.
// ---------------------------------------------------------------------------
// Input stream s_axis: one raw token byte per item, tlast on the final byte.
// Output stream m_axis: tuser = 0 for a decoded data byte, 1 for the end item
// that carries the token's byte count; tlast marks the final result of an
// input item. Each input item gives zero to three results.
// cfg_we/cfg_wdata write max_bytes (reset 1024); write only while idle.
// Input is taken every cycle while the result queue has room (QUEUE_DEPTH
// records). A result passes through the queue and then the output register.
// Throughput: one input item per cycle while the queue has room, and one
// result per cycle at the output while m_axis_tready is high, so an item's
// results leave the output one after another.
// When m_axis_tready is low the output register holds, the queue fills and
// s_axis_tready drops once all QUEUE_DEPTH records are in use.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// returns the decoder to the start of a token.
// ---------------------------------------------------------------------------
module string_escape_decoder_core #(
  parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] byte_count
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last_in_run
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata       // max_bytes
);
  import sed_pkg::*;

  logic [CNT_W-1:0] max_bytes;
  logic             q_full, q_push, q_pop, head_valid;
  sed_rec_t         push_rec, head_rec;
  logic [7:0]       out_byte;
  logic [CNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) max_bytes <= MAX_BYTES_RESET;
    else if (cfg_we) max_bytes <= cfg_wdata;
  end

  sed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .raw_byte  (s_axis_tdata),
    .is_last   (s_axis_tlast),
    .max_bytes (max_bytes),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  sed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  sed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_byte   (out_byte),
    .out_count  (out_count),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_byte};

endmodule

// File: src/sed_checker.sv
// ---------------------------------------------------------------------------
// sed_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "string_escape_decoder_core_defines.svh"

module sed_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  `SED_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `SED_ASSERT_IMP(a_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "end item not marked last")
  `SED_ASSERT_IMP(a_end_byte_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == 8'd0, "end item carries a data byte")
  `SED_ASSERT_IMP(a_data_cnt_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[23:8] == 16'd0, "data item carries a count")
  `SED_ASSERT_RST(a_reset_idle, rst, !m_axis_tvalid, "result valid after reset")

endmodule

bind string_escape_decoder_core sed_checker u_sed_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: bench/sed_decode_checker.sv
// ---------------------------------------------------------------------------
// sed_decode_checker
// Watches both streams and the max_bytes write port of the escape decoder,
// predicts the decoded results of every accepted raw byte and compares each
// accepted result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module sed_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
  input  logic        s_axis_tlast,   // is_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] byte_count
  input  logic        m_axis_tuser,   // kind
  input  logic        m_axis_tlast,   // last_in_run
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // max_bytes
  output int          fail_count,
  output int          pending
);
  import sed_pkg::*;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_PLAIN = 3'd1,
    ST_ESC   = 3'd2,
    ST_HEX1  = 3'd3,
    ST_HEX2  = 3'd4,
    ST_DONE  = 3'd5
  } dec_mode_e;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
    logic             run_end;
  } dec_result_t;

  dec_mode_e        mode;
  logic [7:0]       held_digit;
  logic [CNT_W-1:0] byte_total;
  logic [CNT_W-1:0] byte_limit;

  dec_result_t decoded_q[$];   // decoded results still to come out
  dec_result_t step_q[$];      // results of the raw byte being decoded
  dec_result_t got;
  dec_result_t want;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;        // 0-9
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;   // a-f
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;   // A-F
    return -1;
  endfunction

  // data byte, dropped silently once the per-token limit is reached
  function automatic void put_byte(input logic [7:0] b);
    dec_result_t r;
    if (byte_total < byte_limit) begin
      r = '0;
      r.data = b;
      step_q.push_back(r);
      byte_total = byte_total + 1'b1;
    end
  endfunction

  function automatic void plain_text(input logic [7:0] c, input logic last);
    if (c == CH_QUOTE) begin
      mode = ST_DONE;
    end else if (c == CH_BSLASH && !last) begin
      mode = ST_ESC;
    end else begin
      put_byte(c);
      mode = ST_PLAIN;
    end
  endfunction

  function automatic void decode_step(input logic [7:0] c, input logic last);
    dec_result_t r;
    logic [7:0]  v;
    step_q.delete();
    case (mode)
      ST_START: begin
        if (c == CH_QUOTE) mode = ST_PLAIN;
        else plain_text(c, last);
      end
      ST_ESC: begin
        mode = ST_PLAIN;
        if (c == CH_N) put_byte(CH_LF);
        else if (c == CH_R) put_byte(CH_CR);
        else if (c == CH_T) put_byte(CH_TAB);
        else if (c == CH_BSLASH) put_byte(CH_BSLASH);
        else if (c == CH_QUOTE) put_byte(CH_QUOTE);
        else if (c == CH_X) begin
          if (!last) mode = ST_HEX1;
        end else put_byte(CH_BSLASH);
      end
      ST_HEX1: begin
        if (!last && nibble_of(c) >= 0) begin
          held_digit = c;
          mode = ST_HEX2;
        end else begin
          plain_text(c, last);
        end
      end
      ST_HEX2: begin
        if (nibble_of(c) >= 0) begin
          v = 8'((nibble_of(held_digit) << 4) | nibble_of(c));
          put_byte(v);
          mode = ST_PLAIN;
        end else begin
          // bad escape: held digit goes out as text first
          put_byte(held_digit);
          plain_text(c, last);
        end
        held_digit = '0;
      end
      ST_DONE: ;
      default: plain_text(c, last);
    endcase
    if (last) begin
      r = '0;
      r.kind = 1'b1;
      r.count = byte_total;
      step_q.push_back(r);
      mode = ST_START;
      held_digit = '0;
      byte_total = '0;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_end = 1'b1;
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    mode = ST_START;
    held_digit = '0;
    byte_total = '0;
    byte_limit = MAX_BYTES_RESET;
  end

  always @(posedge clk) begin
    if (rst) begin
      mode = ST_START;
      held_digit = '0;
      byte_total = '0;
      byte_limit = MAX_BYTES_RESET;
      decoded_q.delete();
    end else begin
      // results first: a result never comes from a byte taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.data = m_axis_tdata[7:0];
        got.count = m_axis_tdata[23:8];
        got.run_end = m_axis_tlast;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %h count %0d last %0d", $time,
                   got.kind, got.data, got.count, got.run_end);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.count !== want.count || got.run_end !== want.run_end) begin
            $display("%0t: mismatch: expected kind %0d byte %h count %0d last %0d", $time,
                     want.kind, want.data, want.count, want.run_end);
            $display("%0t:           actual kind %0d byte %h count %0d last %0d", $time,
                     got.kind, got.data, got.count, got.run_end);
            fail_count++;
          end
        end
      end
      if (cfg_we) byte_limit = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) decode_step(s_axis_tdata, s_axis_tlast);
    end
    pending = decoded_q.size();
  end

endmodule

// File: bench/string_escape_decoder_core_tb.sv
// ---------------------------------------------------------------------------
// string_escape_decoder_core_tb
// Drives quoted string tokens into the escape decoder: a few directed tokens
// for every escape and corner, then random tokens under several max_bytes
// settings, with bursty input and a stalling output. Checking is done by
// sed_decode_checker; this module makes stimulus and reports the verdict.
// ---------------------------------------------------------------------------
module string_escape_decoder_core_tb;
  import sed_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 170;
  localparam int SETTLE_CYCLES = 16;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;
  int cycle_count;
  int burst_left;
  int rx_mode;
  int rx_left;
  int sent_items;

  logic [7:0] token_bytes[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  string_escape_decoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  sed_decode_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // output side: free run, random, mostly ready, or a solid stall
  initial begin
    rx_mode = 0;
    rx_left = 0;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(1, 20) : $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= 1'b0;
    endcase
  end

  function automatic logic [7:0] hex_char(input int i);
    if (i < 10) return 8'(8'h30 + i);
    if (i < 16) return 8'(8'h61 + i - 10);
    return 8'(8'h41 + i - 16);
  endfunction

  task automatic send_raw(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_token();
    for (int i = 0; i < token_bytes.size(); i++)
      send_raw(token_bytes[i], i == token_bytes.size() - 1);
  endtask

  // hold the input until every predicted result is out, then let it settle
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int body;
    int junk;
    int phase;
    logic [15:0] lim;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    sent_items = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // quoted token with every simple escape, then bytes after the close quote
    token_bytes = {CH_QUOTE, CH_BSLASH, CH_N, CH_BSLASH, CH_T, CH_BSLASH, CH_BSLASH,
                   CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_R, CH_QUOTE, 8'h58};
    send_token();
    // unquoted: good hex, unknown escape, held digit then bad char on last byte
    token_bytes = {CH_BSLASH, CH_X, 8'h34, 8'h46, CH_BSLASH, 8'h71, CH_BSLASH, CH_X,
                   8'h61, 8'h7A};
    send_token();
    // byte extremes and a lone backslash at the end
    token_bytes = {8'hFF, 8'h00, CH_BSLASH};
    send_token();

    phase = 0;
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (sent_items >= phase * 30) begin
        case (phase % 7)
          0:       lim = 16'd0;
          1:       lim = 16'hFFFF;
          2:       lim = 16'd1;
          3:       lim = 16'd3;
          4:       lim = 16'($urandom_range(2, 12));
          5:       lim = 16'($urandom);
          default: lim = MAX_BYTES_RESET;
        endcase
        write_limit(lim);
        phase++;
      end else if ($urandom_range(0, 15) == 0) begin
        wait_idle();
      end

      token_bytes.delete();
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 9) != 0) token_bytes.push_back(CH_QUOTE);
        body = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
        repeat (body) begin
          case ($urandom_range(0, 9))
            0, 1, 2: token_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            3: begin
              token_bytes.push_back(CH_BSLASH);
              case ($urandom_range(0, 4))
                0:       token_bytes.push_back(CH_N);
                1:       token_bytes.push_back(CH_R);
                2:       token_bytes.push_back(CH_T);
                3:       token_bytes.push_back(CH_BSLASH);
                default: token_bytes.push_back(CH_QUOTE);
              endcase
            end
            4: begin
              token_bytes.push_back(CH_BSLASH);
              token_bytes.push_back(CH_X);
              token_bytes.push_back(hex_char($urandom_range(0, 21)));
              token_bytes.push_back(hex_char($urandom_range(0, 21)));
            end
            5: begin
              // broken hex escape, one digit or none
              token_bytes.push_back(CH_BSLASH);
              token_bytes.push_back(CH_X);
              if ($urandom_range(0, 1)) token_bytes.push_back(hex_char($urandom_range(0, 21)));
              token_bytes.push_back(8'($urandom_range(8'h67, 8'h7E)));
            end
            6: begin
              token_bytes.push_back(CH_BSLASH);
              token_bytes.push_back(8'($urandom_range(0, 255)));
            end
            7: token_bytes.push_back(8'($urandom_range(0, 255)));
            default: token_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
          endcase
        end
        if ($urandom_range(0, 4) != 0) begin
          token_bytes.push_back(CH_QUOTE);
          junk = $urandom_range(0, 2);
          repeat (junk) token_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        body = $urandom_range(1, 8);
        repeat (body) token_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (token_bytes.size() == 0) token_bytes.push_back(8'($urandom_range(0, 255)));
      send_token();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
